FILE: src/ldm_pkg.sv
// ----------------------------------------------------------------------------
// ldm_pkg
// Shared types, byte codes and the response dictionary of the line matcher.
// ----------------------------------------------------------------------------
package ldm_pkg;

    localparam int unsigned C_DICT_N      = 18;
    localparam int unsigned C_ENTRY_BYTES = 48;
    localparam int unsigned C_CODE_W      = 5;

    typedef logic [C_DICT_N-1:0]        t_flags;
    typedef logic [C_CODE_W-1:0]        t_code;
    typedef logic [C_ENTRY_BYTES*8-1:0] t_entry;

    localparam t_code       C_CODE_UNKNOWN = t_code'(C_DICT_N);
    localparam logic [7:0]  C_BYTE_CR      = 8'h0D;
    localparam logic [7:0]  C_BYTE_LF      = 8'h0A;
    localparam int unsigned C_MIN_LINE     = 2;

    // Entries are right-justified: the last byte of a string is in bits [7:0].
    localparam t_entry C_DICT [C_DICT_N] = '{
        "Successfully actuated mechanical brake\015\012",
        "Failed to actuate mechanical brake\015\012",
        "Timeout while actuating mechanical brake\015\012",
        "SMA retracted\015\012",
        "SMA extending\015\012",
        "SMA extended\015\012",
        "BLDC motor speed stabilized\015\012",
        "BLDC motor timeout\015\012",
        "BLDC motor acceleration complete\015\012",
        "BLDC motor coasting to stop\015\012",
        "BLDC motor stopped\015\012",
        "Motion primitive unrecognized\015\012",
        "Stopping BLDC motor with electric brake...\015\012",
        "Problem stopping BLDC motor\015\012",
        "Starting BLDC motor spinning forward...\015\012",
        "Starting BLDC motor spinning reverse...\015\012",
        "Starting inertial actuation...\015\012",
        "Inertial actuation complete\015\012"
    };

    function automatic int unsigned ent_len(t_entry s);
        int unsigned n;
        n = 0;
        for (int j = 0; j < C_ENTRY_BYTES; j++) begin
            if (s[j*8 +: 8] != 8'h00) begin
                n = j + 1;
            end
        end
        return n;
    endfunction

endpackage

FILE: src/ldm_match.sv
// ----------------------------------------------------------------------------
// ldm_match
// Per-entry candidate update and first-match encoding for one received byte.
// ----------------------------------------------------------------------------
module ldm_match #(
    parameter int unsigned LEN_W = 7
) (
    input  logic [LEN_W-1:0]   i_len,
    input  logic [7:0]         i_byte,
    input  ldm_pkg::t_flags    i_flags,
    output ldm_pkg::t_flags    o_flags,
    output ldm_pkg::t_code     o_code
);

    ldm_pkg::t_flags w_hit;

    for (genvar g = 0; g < ldm_pkg::C_DICT_N; g++) begin : g_ent
        localparam int unsigned L = ldm_pkg::ent_len(ldm_pkg::C_DICT[g]);
        logic [7:0] w_exp;

        always_comb begin
            w_exp = 8'h00;
            for (int j = 0; j < L; j++) begin
                if (i_len == LEN_W'(j)) begin
                    w_exp = ldm_pkg::C_DICT[g][(L-1-j)*8 +: 8];
                end
            end
        end

        assign o_flags[g] = i_flags[g] && (i_len < LEN_W'(L)) && (i_byte == w_exp);
        assign w_hit[g]   = o_flags[g] && (i_len == LEN_W'(L - 1));
    end

    always_comb begin
        o_code = ldm_pkg::C_CODE_UNKNOWN;
        for (int k = ldm_pkg::C_DICT_N - 1; k >= 0; k--) begin
            if (w_hit[k]) begin
                o_code = ldm_pkg::t_code'(k);
            end
        end
    end

endmodule

FILE: src/line_dictionary_matcher_core.sv
// ----------------------------------------------------------------------------
// line_dictionary_matcher_core
// Collects received bytes into lines ended by CR LF and reports which
// dictionary response the line equals, or unknown.
// ----------------------------------------------------------------------------
//  channel  valid          stall          payload
//  input    i_in_valid     o_in_stall     i_rx_byte
//  output   o_out_valid    i_out_stall    o_response_code
//
//  One byte is taken every cycle while o_in_stall is low; all candidate flags update in parallel.
//  The code is registered and appears in the cycle after the LF that ends the line is taken.
//  o_in_stall rises only while a code is held and i_out_stall is high.
//  Synchronous reset clears the line state and the output register.
// ----------------------------------------------------------------------------
module line_dictionary_matcher_core #(
    parameter int unsigned LINE_CAPACITY = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ldm_pkg::t_code        o_response_code
);

    localparam int unsigned LEN_W = $clog2(LINE_CAPACITY + 1);

    logic [LEN_W-1:0] r_len,   n_len;
    ldm_pkg::t_flags  r_flags, n_flags;
    logic             r_cr,    n_cr;
    logic             r_ovf,   n_ovf;
    logic             r_out_valid, n_out_valid;
    ldm_pkg::t_code   r_code,  n_code;

    ldm_pkg::t_flags  w_mflags;
    ldm_pkg::t_code   w_mcode;
    logic             w_acc;
    logic             w_sat;
    logic             w_fire;
    logic [LEN_W-1:0] w_len;

    ldm_match #(
        .LEN_W (LEN_W)
    ) u_match (
        .i_len   (r_len),
        .i_byte  (i_rx_byte),
        .i_flags (r_flags),
        .o_flags (w_mflags),
        .o_code  (w_mcode)
    );

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_sat      = (r_len >= LEN_W'(LINE_CAPACITY));
    assign w_len      = w_sat ? r_len : r_len + LEN_W'(1);
    assign w_fire     = r_cr && (i_rx_byte == ldm_pkg::C_BYTE_LF)
                        && (w_len >= LEN_W'(ldm_pkg::C_MIN_LINE));

    always_comb begin
        n_len       = r_len;
        n_flags     = r_flags;
        n_cr        = r_cr;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && i_out_stall;
        n_code      = r_code;
        if (w_acc) begin
            if (w_fire) begin
                n_len       = '0;
                n_flags     = '1;
                n_cr        = 1'b0;
                n_ovf       = 1'b0;
                n_out_valid = 1'b1;
                n_code      = (r_ovf || w_sat) ? ldm_pkg::C_CODE_UNKNOWN : w_mcode;
            end else begin
                n_len   = w_len;
                n_flags = w_sat ? '0 : w_mflags;
                n_cr    = (i_rx_byte == ldm_pkg::C_BYTE_CR);
                n_ovf   = r_ovf || w_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_flags     <= '1;
            r_cr        <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_code      <= ldm_pkg::C_CODE_UNKNOWN;
        end else begin
            r_len       <= n_len;
            r_flags     <= n_flags;
            r_cr        <= n_cr;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_code      <= n_code;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_response_code = r_code;

endmodule

FILE: src/ldm_chk.sv
// ----------------------------------------------------------------------------
// ldm_chk
// Port-level checks of the line matcher, bound to the top level.
// ----------------------------------------------------------------------------
module ldm_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic [7:0]           i_rx_byte,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input ldm_pkg::t_code       o_response_code
);

    logic w_acc;
    assign w_acc = i_in_valid && !o_in_stall;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_response_code))
        else $error("held code changed or dropped");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_response_code <= ldm_pkg::C_CODE_UNKNOWN)
        else $error("code out of range");

    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_acc))
        else $error("code without an accepted byte");

    a_crlf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_rx_byte == ldm_pkg::C_BYTE_LF) && $past(i_rst_n)
        && $past(w_acc && (i_rx_byte == ldm_pkg::C_BYTE_CR)) |=> o_out_valid)
        else $error("CR LF gave no code");

endmodule

bind line_dictionary_matcher_core ldm_chk u_ldm_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_rx_byte       (i_rx_byte),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_response_code (o_response_code)
);

FILE: verif/line_dictionary_matcher_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_dictionary_matcher_core_tb
// Feeds byte streams into the line matcher and checks every response code
// against a software copy of the line state and the response dictionary.
// Covers exact responses, altered, cut and stretched lines, random noise and
// over-long lines, under source gaps and sink stalls.
// ----------------------------------------------------------------------------
module line_dictionary_matcher_core_tb;

    localparam int unsigned LINE_CAP   = 64;
    localparam int unsigned WORD_GOAL  = 700;
    localparam int unsigned CYCLE_CAP  = 500000;

    typedef enum int unsigned {
        PH_STEADY,
        PH_SLOW_SOURCE,
        PH_SLOW_SINK,
        PH_MIXED
    } t_phase;

    class response_scoreboard;
        string           resp [ldm_pkg::C_DICT_N];
        int unsigned     line_len;
        ldm_pkg::t_flags live;
        bit              after_cr;
        bit              overflowed;
        ldm_pkg::t_code  codes_due [$];
        int unsigned     codes_made;
        int unsigned     errors;

        function new();
            resp = '{
                "Successfully actuated mechanical brake",
                "Failed to actuate mechanical brake",
                "Timeout while actuating mechanical brake",
                "SMA retracted",
                "SMA extending",
                "SMA extended",
                "BLDC motor speed stabilized",
                "BLDC motor timeout",
                "BLDC motor acceleration complete",
                "BLDC motor coasting to stop",
                "BLDC motor stopped",
                "Motion primitive unrecognized",
                "Stopping BLDC motor with electric brake...",
                "Problem stopping BLDC motor",
                "Starting BLDC motor spinning forward...",
                "Starting BLDC motor spinning reverse...",
                "Starting inertial actuation...",
                "Inertial actuation complete"
            };
            codes_made = 0;
            errors     = 0;
            restart();
        endfunction

        function void restart();
            line_len   = 0;
            live       = '1;
            after_cr   = 1'b0;
            overflowed = 1'b0;
        endfunction

        function int unsigned resp_len(int unsigned k);
            return resp[k].len() + 2;
        endfunction

        function logic [7:0] resp_byte(int unsigned k, int unsigned i);
            if (i < resp[k].len()) begin
                return resp[k].getc(i);
            end
            return (i == resp[k].len()) ? ldm_pkg::C_BYTE_CR : ldm_pkg::C_BYTE_LF;
        endfunction

        function void note_word(logic [7:0] b);
            bit             ends_line;
            ldm_pkg::t_code code;
            ends_line = after_cr && (b == ldm_pkg::C_BYTE_LF);
            if (line_len >= LINE_CAP) begin
                overflowed = 1'b1;
                live       = '0;
            end else begin
                for (int k = 0; k < ldm_pkg::C_DICT_N; k++) begin
                    if (live[k] && (line_len >= resp_len(k) || resp_byte(k, line_len) != b)) begin
                        live[k] = 1'b0;
                    end
                end
                line_len++;
            end
            after_cr = (b == ldm_pkg::C_BYTE_CR);
            if (ends_line && line_len >= ldm_pkg::C_MIN_LINE) begin
                code = ldm_pkg::C_CODE_UNKNOWN;
                if (!overflowed) begin
                    for (int k = 0; k < ldm_pkg::C_DICT_N; k++) begin
                        if (live[k] && resp_len(k) == line_len) begin
                            code = ldm_pkg::t_code'(k);
                            break;
                        end
                    end
                end
                codes_due.push_back(code);
                codes_made++;
                restart();
            end
        endfunction

        function void check_code(ldm_pkg::t_code got);
            ldm_pkg::t_code want;
            if (codes_due.size() == 0) begin
                errors++;
                $display("%0t: response_code expected none, actual %0d", $time, got);
                return;
            end
            want = codes_due.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: response_code expected %0d, actual %0d", $time, want, got);
            end
        endfunction
    endclass

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    logic [7:0]     i_rx_byte   = 8'h00;
    logic           i_out_stall = 1'b0;
    logic           o_in_stall;
    logic           o_out_valid;
    ldm_pkg::t_code o_response_code;

    response_scoreboard sb;
    logic [7:0]         line_q [$];
    int unsigned        idle_pct;
    int unsigned        stall_pct;
    int unsigned        words_sent;
    int unsigned        lines_sent;
    int unsigned        cycles = 0;

    line_dictionary_matcher_core #(
        .LINE_CAPACITY(LINE_CAP)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_response_code(o_response_code)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // sample between edges; the word moves at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_code(o_response_code);
        end
    end

    task automatic set_phase(t_phase ph);
        case (ph)
            PH_STEADY: begin
                idle_pct = 0;
                stall_pct = 0;
            end
            PH_SLOW_SOURCE: begin
                idle_pct = 82;
                stall_pct = 0;
            end
            PH_SLOW_SINK: begin
                idle_pct = 0;
                stall_pct = 82;
            end
            default: begin
                idle_pct = 14;
                stall_pct = 14;
            end
        endcase
    endtask

    task automatic send_word(logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(negedge i_clk);
        while (o_in_stall) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        sb.note_word(b);
        words_sent++;
    endtask

    task automatic send_line();
        foreach (line_q[i]) begin
            send_word(line_q[i]);
        end
        lines_sent++;
    endtask

    task automatic push_crlf();
        line_q.push_back(ldm_pkg::C_BYTE_CR);
        line_q.push_back(ldm_pkg::C_BYTE_LF);
    endtask

    task automatic build_line();
        int unsigned pick;
        int unsigned k;
        int unsigned n;
        int unsigned p;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, ldm_pkg::C_DICT_N - 1);
        n    = sb.resp[k].len();
        line_q.delete();
        if (pick < 60) begin
            for (int i = 0; i < n + 2; i++) begin
                line_q.push_back(sb.resp_byte(k, i));
            end
            // corrupt one byte, CR and LF included
            if (pick >= 45) begin
                p = $urandom_range(0, n + 1);
                line_q[p] = 8'($urandom_range(0, 255));
            end
        end else if (pick < 68) begin
            p = $urandom_range(0, n - 1);
            for (int i = 0; i < p; i++) begin
                line_q.push_back(sb.resp_byte(k, i));
            end
            push_crlf();
        end else if (pick < 74) begin
            if (pick[0]) begin
                line_q.push_back(8'($urandom_range(0, 255)));
            end
            for (int i = 0; i < n; i++) begin
                line_q.push_back(sb.resp_byte(k, i));
            end
            if (!pick[0]) begin
                line_q.push_back(8'($urandom_range(0, 255)));
            end
            push_crlf();
        end else if (pick < 84) begin
            p = $urandom_range(0, 10);
            for (int i = 0; i < p; i++) begin
                line_q.push_back(8'($urandom_range(0, 255)));
            end
            push_crlf();
        end else if (pick < 92) begin
            p = $urandom_range(LINE_CAP - 4, LINE_CAP + 4);
            for (int i = 0; i < p; i++) begin
                b = 8'($urandom_range(0, 255));
                line_q.push_back((b == ldm_pkg::C_BYTE_LF) ? 8'h00 : b);
            end
            push_crlf();
        end else begin
            p = $urandom_range(1, 20);
            for (int i = 0; i < p; i++) begin
                line_q.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        sb         = new();
        words_sent = 0;
        lines_sent = 0;
        set_phase(PH_STEADY);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        line_q = '{8'h00, 8'hFF, ldm_pkg::C_BYTE_CR, ldm_pkg::C_BYTE_LF,
                   ldm_pkg::C_BYTE_LF,
                   ldm_pkg::C_BYTE_CR, ldm_pkg::C_BYTE_LF,
                   ldm_pkg::C_BYTE_CR, ldm_pkg::C_BYTE_CR, ldm_pkg::C_BYTE_LF,
                   8'h53, ldm_pkg::C_BYTE_CR, 8'h78, ldm_pkg::C_BYTE_LF,
                   ldm_pkg::C_BYTE_CR, ldm_pkg::C_BYTE_LF};
        send_line();

        while (words_sent < WORD_GOAL) begin
            set_phase(t_phase'((lines_sent / 6) % 4));
            build_line();
            send_line();
        end
        i_in_valid <= 1'b0;

        while (sb.codes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        if (sb.errors == 0 && sb.codes_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
